>>> rtl/core/assert_macros.svh
// assertion helpers, compiled out when ASSERT_OFF is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/lfu_pkg.sv
package lfu_pkg;

    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = 32;
    localparam int STAMP_W     = 32;
    localparam int CFG_W       = 5;
    localparam int ENTRIES_DEF = 16;

    localparam logic [CFG_W-1:0]   CAP_RESET  = 5'd16;
    localparam logic               OP_GET     = 1'b0;
    localparam logic               OP_PUT     = 1'b1;
    localparam logic [CNT_W-1:0]   CNT_SAT    = {CNT_W{1'b1}};
    localparam logic [STAMP_W-1:0] STAMP_SAT  = {STAMP_W{1'b1}};
    localparam logic [DATA_W-1:0]  MISS_VALUE = {DATA_W{1'b1}};
    localparam logic [CNT_W-1:0]   CNT_FIRST  = 32'd1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  data;
        logic [CNT_W-1:0]   count;
        logic [STAMP_W-1:0] stamp;
    } t_slot;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_SAT) ? v : v + CNT_W'(1);
    endfunction

endpackage

>>> rtl/core/lfu_slot_ram.sv
module lfu_slot_ram #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF,
    parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [IW-1:0]        i_waddr,
    input  lfu_pkg::t_slot       i_wdata,
    input  logic [IW-1:0]        i_raddr,
    output lfu_pkg::t_slot       o_rdata
);

    lfu_pkg::t_slot r_mem [ENTRIES];
    lfu_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/lfu_cache_table_unit.sv
// lfu cache table: key-value cache, least-frequently-used replacement with
// least-recently-touched tie break.
// input channel (i_in_valid / o_in_ready) carries one item: i_op (get/put),
// i_lookup_key and i_store_value. output channel (o_out_valid / i_out_ready)
// returns one item per input item: o_hit and o_read_value (-1 on miss/put).
// i_cfg_we writes i_cfg_wdata into the capacity register at once; write it
// only while the block is idle. capacity is clamped to ENTRIES.
// an item is handled in order: one read of the slot memory per cycle sweeps
// all entries for a key match, the victim and the first free slot, then the
// write-back updates at most a single slot. o_in_ready is high only while
// idle, so the next item is taken only once the current one is finished,
// as the sweep holds the single read port of the slot memory.
// a finished result sits in an output register; if the receiver stalls, the
// next item is still accepted and swept, and the write-back waits for the
// output register to free up.
// synchronous reset (i_rst_n low) clears all valid marks, the op clock and
// the handshake state, and sets the capacity to 16.
`include "assert_macros.svh"

module lfu_cache_table_unit #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_op,
    input  logic signed [31:0]          i_lookup_key,
    input  logic signed [31:0]          i_store_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_hit,
    output logic signed [31:0]          o_read_value
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = (CW > lfu_pkg::CFG_W) ? CW : lfu_pkg::CFG_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_LAST   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                    r_state;
    logic [lfu_pkg::CFG_W-1:0]     r_cap;
    logic [ENTRIES-1:0]            r_valid;
    logic [ENTRIES-1:0]            n_valid;
    logic [lfu_pkg::STAMP_W-1:0]   r_op_clock;

    logic                          r_op;
    logic [lfu_pkg::KEY_W-1:0]     r_key;
    logic [lfu_pkg::DATA_W-1:0]    r_val;

    logic [IW-1:0]                 r_scan;
    logic                          r_cmp_vld;
    logic [IW-1:0]                 r_cmp_idx;

    logic                          r_found;
    logic [IW-1:0]                 r_found_idx;
    logic [lfu_pkg::DATA_W-1:0]    r_found_data;
    logic [lfu_pkg::CNT_W-1:0]     r_found_cnt;
    logic                          r_vic_ok;
    logic [IW-1:0]                 r_vic_idx;
    logic [lfu_pkg::CNT_W-1:0]     r_vic_cnt;
    logic [lfu_pkg::STAMP_W-1:0]   r_vic_stamp;
    logic                          r_free_ok;
    logic [IW-1:0]                 r_free_idx;
    logic [CW-1:0]                 r_used;

    logic                          r_out_vld;
    logic                          r_out_hit;
    logic [lfu_pkg::DATA_W-1:0]    r_out_val;

    lfu_pkg::t_slot                w_rd;
    lfu_pkg::t_slot                w_wdata;
    logic                          w_accept;
    logic                          w_done;
    logic                          w_cur_vld;
    logic [XW-1:0]                 w_cap_x;
    logic [CW-1:0]                 w_cap;
    logic                          w_evict;
    logic [CW-1:0]                 w_used_eff;
    logic [IW-1:0]                 w_ins_idx;
    logic                          w_insert;
    logic                          w_we;
    logic [IW-1:0]                 w_waddr;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_done     = (r_state == ST_FINISH) && (!r_out_vld || i_out_ready);
    assign w_cur_vld  = r_valid[r_cmp_idx];

    assign w_cap_x = XW'(r_cap);
    assign w_cap   = (w_cap_x > XW'(ENTRIES)) ? CW'(ENTRIES) : CW'(w_cap_x);

    // eviction only on a new key with the table exactly full
    assign w_evict    = (r_op == lfu_pkg::OP_PUT) && !r_found && (r_used == w_cap) && r_vic_ok;
    assign w_used_eff = w_evict ? r_used - CW'(1) : r_used;
    assign w_ins_idx  = (w_evict && (!r_free_ok || r_vic_idx < r_free_idx)) ? r_vic_idx
                                                                             : r_free_idx;
    assign w_insert   = (r_op == lfu_pkg::OP_PUT) && !r_found && (w_used_eff < w_cap)
                        && (r_free_ok || w_evict);
    assign w_we       = w_done && (r_found || w_insert);
    assign w_waddr    = r_found ? r_found_idx : w_ins_idx;

    always_comb begin
        w_wdata.key = r_key;
        w_wdata.stamp = r_op_clock;
        if (r_found) begin
            w_wdata.data  = (r_op == lfu_pkg::OP_PUT) ? r_val : r_found_data;
            w_wdata.count = lfu_pkg::sat_inc(r_found_cnt);
        end else begin
            w_wdata.data  = r_val;
            w_wdata.count = lfu_pkg::CNT_FIRST;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_done) begin
            if (w_evict) begin
                n_valid[r_vic_idx] = 1'b0;
            end
            if (w_insert) begin
                n_valid[w_ins_idx] = 1'b1;
            end
        end
    end

    lfu_slot_ram #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_scan),
        .o_rdata (w_rd)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cap      <= lfu_pkg::CAP_RESET;
            r_valid    <= '0;
            r_op_clock <= '0;
            r_cmp_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
            r_scan     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_cmp_vld <= (r_state == ST_SCAN);
            r_valid   <= n_valid;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_SCAN;
                        r_scan  <= '0;
                    end
                end
                ST_SCAN: begin
                    r_scan <= r_scan + IW'(1);
                    if (r_scan == IW'(ENTRIES - 1)) begin
                        r_state <= ST_LAST;
                    end
                end
                ST_LAST: begin
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (w_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (w_done) begin
                r_out_vld <= 1'b1;
                if (w_we && r_op_clock != lfu_pkg::STAMP_SAT) begin
                    r_op_clock <= r_op_clock + lfu_pkg::STAMP_W'(1);
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // sweep accumulators, item payload and output result
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_scan;
        if (w_accept) begin
            r_op      <= i_op;
            r_key     <= i_lookup_key;
            r_val     <= i_store_value;
            r_found   <= 1'b0;
            r_vic_ok  <= 1'b0;
            r_free_ok <= 1'b0;
            r_used    <= '0;
        end else if (r_cmp_vld) begin
            if (w_cur_vld) begin
                r_used <= r_used + CW'(1);
                if (!r_found && w_rd.key == r_key) begin
                    r_found      <= 1'b1;
                    r_found_idx  <= r_cmp_idx;
                    r_found_data <= w_rd.data;
                    r_found_cnt  <= w_rd.count;
                end
                // strict compare keeps the lower index on equal pairs
                if (!r_vic_ok || w_rd.count < r_vic_cnt
                    || (w_rd.count == r_vic_cnt && w_rd.stamp < r_vic_stamp)) begin
                    r_vic_ok    <= 1'b1;
                    r_vic_idx   <= r_cmp_idx;
                    r_vic_cnt   <= w_rd.count;
                    r_vic_stamp <= w_rd.stamp;
                end
            end else if (!r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
        end
        if (w_done) begin
            r_out_hit <= r_found;
            r_out_val <= (r_op == lfu_pkg::OP_GET && r_found) ? r_found_data
                                                               : lfu_pkg::MISS_VALUE;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_hit        = r_out_hit;
    assign o_read_value = r_out_val;

    `ASSERT_NEXT(a_accept_starts_scan, i_clk, i_rst_n, w_accept, r_state == ST_SCAN)
    `ASSERT_IMPLIES(a_idle_no_compare, i_clk, i_rst_n, r_state == ST_IDLE, !r_cmp_vld)
    `ASSERT_IMPLIES(a_used_matches_valid, i_clk, i_rst_n, r_state == ST_FINISH, r_used == CW'($countones(r_valid)))
    `ASSERT_IMPLIES(a_single_writer, i_clk, i_rst_n, w_we, w_done && (r_found || w_insert))

endmodule
